// ===== rtl/ihc_pkg.sv =====
// ihc_pkg: types, codes and constants shared by the IPv4 header check block.
// Used by ihc_capture, ihc_verdict and ipv4_header_check; depends on nothing.
`timescale 1ns / 1ps

package ihc_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int POS_W        = $clog2(HEADER_BYTES + 1);
  localparam int ADDR_W       = 32;
  localparam int CFG_IDX_W    = 1;

  localparam logic [POS_W-1:0] POS_VERSION    = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FLAGS_HI   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_FLAGS_LO   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_TTL        = POS_W'(8);
  localparam logic [POS_W-1:0] POS_PROTO      = POS_W'(9);
  localparam logic [POS_W-1:0] POS_CSUM_HI    = POS_W'(10);
  localparam logic [POS_W-1:0] POS_CSUM_LO    = POS_W'(11);
  localparam logic [POS_W-1:0] POS_DEST_FIRST = POS_W'(16);
  localparam logic [POS_W-1:0] POS_LAST       = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_END        = POS_W'(HEADER_BYTES);

  localparam logic [7:0]  VERSION_IHL   = 8'h45;
  localparam logic [15:0] FRAG_MASK     = 16'h3FFF;
  localparam logic [7:0]  PROTO_ICMP    = 8'd1;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [3:0]  MCAST_PREFIX  = 4'hE;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_VERSION  = 3'd1,
    ST_FRAGMENT = 3'd2,
    ST_TTL      = 3'd3,
    ST_NOT_OURS = 3'd4,
    ST_CHECKSUM = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    HC_ICMP  = 2'd0,
    HC_UDP   = 2'd1,
    HC_OTHER = 2'd2
  } hclass_t;

  typedef enum logic [1:0] {
    DK_OWN   = 2'd0,
    DK_BCAST = 2'd1,
    DK_MCAST = 2'd2,
    DK_NONE  = 2'd3
  } dest_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] protocol;
    hclass_t    handler_class;
    dest_kind_t dest_kind;
  } out_t;

  // Header digest handed from capture to verdict
  typedef struct packed {
    logic              version_ok;
    logic              fragment;
    logic              ttl_zero;
    logic [7:0]        protocol;
    logic [ADDR_W-1:0] dest;
    logic [15:0]       sum;
    logic [15:0]       stored_csum;
  } hdr_t;

endpackage

// ===== rtl/ihc_capture.sv =====
// ihc_capture: byte counter, header field capture and ones-complement sum.
// Holds one finished header digest for ihc_verdict. Depends on ihc_pkg.
`timescale 1ns / 1ps

module ihc_capture (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_accept,
  input  ihc_pkg::in_t  in_data,
  input  logic          snap_take,
  output logic          snap_valid,
  output ihc_pkg::hdr_t snap
);

  logic [ihc_pkg::POS_W-1:0]  pos_r, pos_nxt, pos_eff;
  logic [15:0]                sum_r, sum_nxt, sum_eff, sum_fold;
  logic [16:0]                sum_wide;
  logic [7:0]                 hi_r, hi_nxt;
  logic [7:0]                 ver_r, ver_nxt;
  logic [15:0]                flags_r, flags_nxt;
  logic [7:0]                 ttl_r, ttl_nxt;
  logic [7:0]                 proto_r, proto_nxt;
  logic [15:0]                csum_r, csum_nxt;
  logic [ihc_pkg::ADDR_W-1:0] dest_r, dest_nxt;
  logic                       snap_v_r, snap_v_nxt;
  ihc_pkg::hdr_t              snap_r, snap_nxt;
  logic                       in_header, emit;
  logic [7:0]                 b;

  assign b         = in_data.data_byte;
  assign pos_eff   = in_data.packet_start ? '0 : pos_r;
  assign sum_eff   = in_data.packet_start ? '0 : sum_r;
  assign in_header = pos_eff < ihc_pkg::POS_END;
  assign emit      = in_accept && in_header && (pos_eff == ihc_pkg::POS_LAST);

  // end-around carry add of the completed word
  assign sum_wide = {1'b0, sum_eff} + {1'b0, hi_r, b};
  assign sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    hi_nxt    = hi_r;
    ver_nxt   = ver_r;
    flags_nxt = flags_r;
    ttl_nxt   = ttl_r;
    proto_nxt = proto_r;
    csum_nxt  = csum_r;
    dest_nxt  = dest_r;
    if (in_accept && in_data.packet_start) begin
      pos_nxt = '0;
      sum_nxt = '0;
    end
    if (in_accept && in_header) begin
      pos_nxt = pos_eff + ihc_pkg::POS_W'(1);
      if (pos_eff == ihc_pkg::POS_VERSION) ver_nxt = b;
      if (pos_eff == ihc_pkg::POS_FLAGS_HI) flags_nxt[15:8] = b;
      if (pos_eff == ihc_pkg::POS_FLAGS_LO) flags_nxt[7:0] = b;
      if (pos_eff == ihc_pkg::POS_TTL) ttl_nxt = b;
      if (pos_eff == ihc_pkg::POS_PROTO) proto_nxt = b;
      if (pos_eff == ihc_pkg::POS_CSUM_HI) csum_nxt[15:8] = b;
      if (pos_eff == ihc_pkg::POS_CSUM_LO) csum_nxt[7:0] = b;
      if (pos_eff >= ihc_pkg::POS_DEST_FIRST) dest_nxt = {dest_r[ihc_pkg::ADDR_W-9:0], b};
      if (!pos_eff[0]) begin
        hi_nxt = b;
      end else if (pos_eff != ihc_pkg::POS_CSUM_LO) begin
        sum_nxt = sum_fold;
      end
    end
  end

  always_comb begin
    snap_nxt             = snap_r;
    snap_nxt.version_ok  = ver_r == ihc_pkg::VERSION_IHL;
    snap_nxt.fragment    = (flags_r & ihc_pkg::FRAG_MASK) != '0;
    snap_nxt.ttl_zero    = ttl_r == '0;
    snap_nxt.protocol    = proto_r;
    snap_nxt.dest        = dest_nxt;
    snap_nxt.sum         = sum_nxt;
    snap_nxt.stored_csum = csum_r;
    if (!emit) snap_nxt = snap_r;
    snap_v_nxt = emit ? 1'b1 : (snap_take ? 1'b0 : snap_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      snap_v_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      snap_v_r <= snap_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r    <= hi_nxt;
    ver_r   <= ver_nxt;
    flags_r <= flags_nxt;
    ttl_r   <= ttl_nxt;
    proto_r <= proto_nxt;
    csum_r  <= csum_nxt;
    dest_r  <= dest_nxt;
    snap_r  <= snap_nxt;
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= ihc_pkg::POS_END)
    else $error("byte position beyond header length");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> snap_v_r && pos_r == ihc_pkg::POS_END)
    else $error("header end did not load digest");

  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v_r && !snap_take && !in_accept |=> snap_v_r && $stable(snap_r))
    else $error("pending digest lost or changed");

endmodule

// ===== rtl/ihc_verdict.sv =====
// ihc_verdict: configuration registers, destination classification, ordered
// checks and the result register. Depends on ihc_pkg.
`timescale 1ns / 1ps

module ihc_verdict (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ihc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ihc_pkg::ADDR_W-1:0]        cfg_wdata,
  input  logic                              snap_valid,
  input  ihc_pkg::hdr_t                     snap,
  output logic                              snap_take,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ihc_pkg::out_t                     out_data
);

  logic [ihc_pkg::ADDR_W-1:0] local_r, local_nxt;
  logic [ihc_pkg::ADDR_W-1:0] mask_r, mask_nxt;
  logic [ihc_pkg::ADDR_W-1:0] host;
  logic                       out_v_r, out_v_nxt;
  ihc_pkg::out_t              out_r, out_nxt, res;
  ihc_pkg::dest_kind_t        kind;
  ihc_pkg::status_t           status;
  ihc_pkg::hclass_t           hclass;

  always_comb begin
    local_nxt = local_r;
    mask_nxt  = mask_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ihc_pkg::CFG_LOCAL_ADDR:  local_nxt = cfg_wdata;
        ihc_pkg::CFG_SUBNET_MASK: mask_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign host = ~mask_r;

  always_comb begin
    priority if (snap.dest == local_r) begin
      kind = ihc_pkg::DK_OWN;
    end else if (&snap.dest || ((snap.dest & host) == host)) begin
      kind = ihc_pkg::DK_BCAST;
    end else if (snap.dest[ihc_pkg::ADDR_W-1 -: 4] == ihc_pkg::MCAST_PREFIX) begin
      kind = ihc_pkg::DK_MCAST;
    end else begin
      kind = ihc_pkg::DK_NONE;
    end
  end

  always_comb begin
    priority if (!snap.version_ok) begin
      status = ihc_pkg::ST_VERSION;
    end else if (snap.fragment) begin
      status = ihc_pkg::ST_FRAGMENT;
    end else if (snap.ttl_zero) begin
      status = ihc_pkg::ST_TTL;
    end else if (kind == ihc_pkg::DK_NONE) begin
      status = ihc_pkg::ST_NOT_OURS;
    end else if (~snap.sum != snap.stored_csum) begin
      status = ihc_pkg::ST_CHECKSUM;
    end else begin
      status = ihc_pkg::ST_OK;
    end
  end

  always_comb begin
    priority if (status != ihc_pkg::ST_OK) begin
      hclass = ihc_pkg::HC_ICMP;
    end else if (snap.protocol == ihc_pkg::PROTO_ICMP) begin
      hclass = ihc_pkg::HC_ICMP;
    end else if (snap.protocol == ihc_pkg::PROTO_UDP) begin
      hclass = ihc_pkg::HC_UDP;
    end else begin
      hclass = ihc_pkg::HC_OTHER;
    end
  end

  always_comb begin
    res.status        = status;
    res.protocol      = snap.protocol;
    res.handler_class = hclass;
    res.dest_kind     = kind;
    snap_take = snap_valid && (!out_v_r || !out_stall);
    out_nxt   = snap_take ? res : out_r;
    out_v_nxt = snap_take || (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_r <= '0;
      mask_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      local_r <= local_nxt;
      mask_r  <= mask_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    snap_take |=> out_v_r)
    else $error("digest taken but no result beat");

  a_class_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.status != ihc_pkg::ST_OK |-> out_r.handler_class == ihc_pkg::HC_ICMP)
    else $error("handler class set on failed header");

  a_none_fails: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.dest_kind == ihc_pkg::DK_NONE |-> out_r.status != ihc_pkg::ST_OK)
    else $error("unmatched destination passed");

endmodule

// ===== rtl/ipv4_header_check.sv =====
// ipv4_header_check: top level of the IPv4 receive header checker.
// Instantiates ihc_capture and ihc_verdict; depends on ihc_pkg.
//
// Usage: packet bytes enter in wire order on in_data, one beat per byte,
// with packet_start set on the first byte of each packet. After the 20th
// header byte one result beat leaves on out_data: status, protocol,
// handler class and destination kind. Shorter packets give no beat and
// bytes past the header are ignored. A start mark mid-header drops the
// partial header.
// Throughput: one byte per cycle while in_stall is low. After the 20th byte
// is accepted the digest register loads, then the result register, which
// drives the result beat.
// cfg_we/cfg_index/cfg_wdata write the local address (index 0) and subnet
// mask (index 1); write them only while no header is in flight.
// Reset (rst_n low, synchronous) clears both registers, the byte counter
// and any pending result. While the receiver stalls, one finished digest
// waits behind the result register; in_stall rises only when both are full.
`timescale 1ns / 1ps

module ipv4_header_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ihc_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ihc_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [ihc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ihc_pkg::ADDR_W-1:0]    cfg_wdata
);

  logic          in_accept;
  logic          snap_valid;
  logic          snap_take;
  ihc_pkg::hdr_t snap;

  assign in_stall  = snap_valid && out_valid;
  assign in_accept = in_valid && !in_stall;

  ihc_capture u_capture (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_data    (in_data),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  ihc_verdict u_verdict (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_take  (snap_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
